>>> rtl/rqsi_pkg.sv
// Shared types, codes and defaults for the ring queue with sorted insert.
package rqsi_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CAP_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int TAG_W = 32;
  localparam int SIZE_W = 48;
  localparam int OCC_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORTEST = 1'b1;

  localparam logic KIND_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_head;
    logic wr_new;
    logic move;
    logic take;
    logic set_full;
    logic set_empty;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic full;
    logic empty;
    logic at_head;
    logic sorted;
    logic new_ge;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/ring_queue_with_sorted_insert_top.sv
// Top level of the ring queue of request descriptors with sorted insert.
//
//   Channel   Direction  Handshake            Payload
//   in_       request    in_valid/in_ready    kind, item_tag, item_size
//   out_      result     out_valid/out_ready  status, tag, size, occupancy
//   cfg_      write      cfg_we               cfg_index, cfg_wdata
//
// From acceptance, a stored or rejected put and a get on an empty queue pass S_CHK and
// then S_RESP for the result load; a get that returns an entry also passes S_GET_DATA.
// A sorted put that is not at the head alternates S_PUT_CMP and S_PUT_STEP, comparing with
// the entry ahead and moving it for each entry it passes, until it stops or reaches the head;
// in_ready returns once the result is loaded, so no new request is taken before then.
// Reset is synchronous and needs no clearing pass; slot contents stay unset.
// A result waiting at the output stalls only the final load of the next request.
module ring_queue_with_sorted_insert_top
  import rqsi_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [TAG_W-1:0]      in_item_tag,
  input  logic [SIZE_W-1:0]     in_item_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [TAG_W-1:0]      out_tag,
  output logic [SIZE_W-1:0]     out_size,
  output logic [OCC_W-1:0]      out_occupancy,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  rqsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rqsi_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_item_tag   (in_item_tag),
    .in_item_size  (in_item_size),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_tag       (out_tag),
    .out_size      (out_size),
    .out_occupancy (out_occupancy),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

>>> rtl/rqsi_ctrl.sv
// Sequencing state machine for puts, sorted insertion steps and gets.
module rqsi_ctrl
  import rqsi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CHK      = 6'b000010,
    S_PUT_STEP = 6'b000100,
    S_PUT_CMP  = 6'b001000,
    S_GET_DATA = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.is_get) begin
          if (stat.empty) begin
            cmd.set_empty = 1'b1;
            state_nxt = S_RESP;
          end else begin
            cmd.rd_en = 1'b1;
            cmd.rd_head = 1'b1;
            state_nxt = S_GET_DATA;
          end
        end else if (stat.full) begin
          cmd.set_full = 1'b1;
          state_nxt = S_RESP;
        end else if (!stat.sorted || stat.at_head) begin
          cmd.wr_new = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_PUT_CMP;
        end
      end
      S_PUT_STEP: begin
        if (stat.at_head) begin
          cmd.wr_new = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_PUT_CMP;
        end
      end
      S_PUT_CMP: begin
        if (stat.new_ge) begin
          cmd.wr_new = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.move = 1'b1;
          state_nxt = S_PUT_STEP;
        end
      end
      S_GET_DATA: begin
        cmd.take = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rqsi_dp.sv
// Datapath: slot memory, ring pointers, configuration and result registers.
module rqsi_dp
  import rqsi_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_kind,
  input  logic [TAG_W-1:0]      in_item_tag,
  input  logic [SIZE_W-1:0]     in_item_size,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [TAG_W-1:0]      out_tag,
  output logic [SIZE_W-1:0]     out_size,
  output logic [OCC_W-1:0]      out_occupancy,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  entry_t mem [DEPTH];

  logic [CAP_W-1:0]  cap_r;
  logic              sf_r;
  logic [IW-1:0]     head_r, tail_r, j_r;
  logic [CW-1:0]     cnt_r;
  logic              kind_r;
  entry_t            new_r;
  entry_t            rd_r;
  status_t           res_status_r;
  entry_t            res_r;
  logic              out_valid_r;
  status_t           out_status_r;
  entry_t            out_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic [EW-1:0] eff_cap, cap_ext, depth_ext, cnt_ext, occ_ext;
  logic [IW-1:0] head_inc, tail_inc, j_dec, rd_addr;
  logic          bad;
  logic          wr_en;
  entry_t        wr_data;

  assign cap_ext   = EW'(cap_r);
  assign depth_ext = EW'(DEPTH);
  assign eff_cap   = (cap_r == '0) ? EW'(1) :
                     ((cap_ext > depth_ext) ? depth_ext : cap_ext);
  assign cnt_ext   = EW'(cnt_r);

  assign bad = (EW'(head_r) >= eff_cap) || (EW'(tail_r) >= eff_cap) ||
               (cnt_ext > eff_cap);

  assign head_inc = ((EW'(head_r) + EW'(1)) == eff_cap) ? '0 : head_r + IW'(1);
  assign tail_inc = ((EW'(tail_r) + EW'(1)) == eff_cap) ? '0 : tail_r + IW'(1);
  assign j_dec    = (j_r == '0) ? IW'(eff_cap - EW'(1)) : j_r - IW'(1);
  assign rd_addr  = cmd.rd_head ? head_r : j_dec;

  assign wr_en   = cmd.wr_new || cmd.move;
  assign wr_data = cmd.move ? rd_r : new_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[j_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      new_r.tag  <= in_item_tag;
      new_r.size <= in_item_size;
    end
    if (cmd.wr_new || cmd.set_full) begin
      res_r <= '0;
    end else if (cmd.set_empty) begin
      res_r <= '0;
    end else if (cmd.take) begin
      res_r <= rd_r;
    end
    if (cmd.wr_new || cmd.take) begin
      res_status_r <= ST_DONE;
    end else if (cmd.set_full) begin
      res_status_r <= ST_FULL;
    end else if (cmd.set_empty) begin
      res_status_r <= ST_EMPTY;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_r        <= res_r;
      out_occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  assign occ_ext = cnt_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      sf_r        <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (bad) begin
          head_r <= '0;
          tail_r <= '0;
          cnt_r  <= '0;
          j_r    <= '0;
        end else begin
          j_r <= tail_r;
        end
      end
      if (cmd.move) begin
        j_r <= j_dec;
      end
      if (cmd.wr_new) begin
        tail_r <= tail_inc;
        cnt_r  <= cnt_r + CW'(1);
      end
      if (cmd.take) begin
        head_r <= head_inc;
        cnt_r  <= cnt_r - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: begin
            cap_r  <= cfg_wdata[CAP_W-1:0];
            head_r <= '0;
            tail_r <= '0;
            cnt_r  <= '0;
          end
          CFG_SHORTEST: begin
            sf_r <= cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign stat.is_get   = (kind_r == KIND_GET);
  assign stat.full     = (cnt_ext >= eff_cap);
  assign stat.empty    = (cnt_r == '0);
  assign stat.at_head  = (j_r == head_r);
  assign stat.sorted   = sf_r;
  assign stat.new_ge   = (new_r.size >= rd_r.size);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_tag       = out_r.tag;
  assign out_size      = out_r.size;
  assign out_occupancy = out_occ_r;

endmodule
